// ===== src/gated_gyro_rate_kalman_macros.svh =====
// Assertion helpers for the top-level block, which checks itself.
`ifndef GATED_GYRO_RATE_KALMAN_MACROS_SVH
`define GATED_GYRO_RATE_KALMAN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GGRK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GGRK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ggrk_pkg.sv =====
package ggrk_pkg;

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_ABSENT = 2'd1,
    ST_JUMPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_GAIN       = 3'd0,
    REG_JUMP_THR   = 3'd1,
    REG_PROC_NOISE = 3'd2,
    REG_MEAS_NOISE = 3'd3,
    REG_INIT_EST   = 3'd4
  } reg_idx_t;

  localparam logic [30:0] PROC_NOISE_RST = 31'd1073742;
  localparam logic [30:0] MEAS_NOISE_RST = 31'd10737418;
  localparam logic [31:0] COV_RST        = 32'd1073741824;
  localparam logic [30:0] ONE_Q30        = 31'd1073741824;
  localparam logic signed [32:0] HALF_DEG = 33'sd32768;
  localparam int unsigned QUO_BITS       = 31;

  // One classified word handed from the front end to the filter.
  typedef struct packed {
    status_t     status;
    logic [32:0] diff;
  } item_t;

  // Filter settings seen by the back end.
  typedef struct packed {
    logic [9:0]  gain;
    logic [30:0] proc_noise;
    logic [30:0] meas_noise;
  } kf_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/ggrk_front.sv =====
module ggrk_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_gyro_angle,
  input  logic [11:0]          in_target_x,
  input  logic [11:0]          in_target_y,
  input  logic [6:0]           jump_thr,
  input  ggrk_pkg::q_stat_t    q_stat,
  output logic                 push,
  output ggrk_pkg::item_t      item
);

  logic [11:0]        last_x_r, last_x_nxt;
  logic [11:0]        last_y_r, last_y_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [31:0]        prev_angle_r, prev_angle_nxt;
  logic [32:0]        last_diff_r, last_diff_nxt;

  logic               absent;
  logic               jumped;
  logic signed [12:0] dx, dy;
  logic signed [25:0] dx2, dy2;
  logic [26:0]        dist2;
  logic [13:0]        thr2;
  logic signed [32:0] diff_raw;
  logic [32:0]        diff;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    absent   = (in_target_x == 12'd0) && (in_target_y == 12'd0);
    dx       = $signed({1'b0, last_x_r}) - $signed({1'b0, in_target_x});
    dy       = $signed({1'b0, last_y_r}) - $signed({1'b0, in_target_y});
    dx2      = dx * dx;
    dy2      = dy * dy;
    dist2    = {1'b0, dx2[25:0]} + {1'b0, dy2[25:0]};
    thr2     = jump_thr * jump_thr;
    jumped   = dist2 > {13'd0, thr2};
    diff_raw = have_prev_r ?
               ($signed({in_gyro_angle[31], in_gyro_angle}) -
                $signed({prev_angle_r[31], prev_angle_r})) : 33'sd0;
    // A sudden large upward step after motion was seen is treated as a glitch.
    if ((last_diff_r != 33'd0) && (diff_raw > ggrk_pkg::HALF_DEG)) begin
      diff = last_diff_r;
    end else begin
      diff = diff_raw;
    end

    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    have_prev_nxt  = have_prev_r;
    prev_angle_nxt = prev_angle_r;
    last_diff_nxt  = last_diff_r;
    item.diff      = diff;
    item.status    = ggrk_pkg::ST_VALID;
    if (absent) begin
      have_prev_nxt = 1'b0;
      item.status   = ggrk_pkg::ST_ABSENT;
    end else begin
      last_x_nxt = in_target_x;
      last_y_nxt = in_target_y;
      if (jumped) begin
        have_prev_nxt = 1'b0;
        item.status   = ggrk_pkg::ST_JUMPED;
      end else begin
        last_diff_nxt  = diff;
        prev_angle_nxt = in_gyro_angle;
        have_prev_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r     <= '0;
      last_y_r     <= '0;
      have_prev_r  <= 1'b0;
      prev_angle_r <= '0;
      last_diff_r  <= '0;
    end else if (push) begin
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      have_prev_r  <= have_prev_nxt;
      prev_angle_r <= prev_angle_nxt;
      last_diff_r  <= last_diff_nxt;
    end
  end

endmodule

// ===== src/ggrk_queue.sv =====
module ggrk_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ggrk_pkg::item_t   push_item,
  input  logic              pop,
  output ggrk_pkg::item_t   head,
  output ggrk_pkg::q_stat_t stat
);

  ggrk_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/ggrk_back.sv =====
module ggrk_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ggrk_pkg::kf_cfg_t cfg,
  input  logic              est_load,
  input  logic [47:0]       est_load_val,
  input  ggrk_pkg::q_stat_t q_stat,
  input  ggrk_pkg::item_t   head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [47:0]       out_prediction,
  output logic [1:0]        out_status
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PRE   = 8'b0000_0010,
    S_INNOV = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_MULA  = 8'b0001_0000,
    S_MULB  = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r;
  logic [47:0]        out_pred_r;
  logic [1:0]         out_status_r;
  logic [47:0]        est_r;
  logic [31:0]        cov_r;
  logic [32:0]        diff_r;
  logic [42:0]        z_r;
  logic [31:0]        ppre_r;
  logic [32:0]        den_r;
  logic [32:0]        rem_r;
  logic               dbit_r;
  logic [30:0]        quo_r;
  logic [4:0]         cnt_r;
  logic [30:0]        k_r;
  logic               neg_r;
  logic [48:0]        mag_r;
  logic [59:0]        a_r;
  logic [50:0]        b_r;
  logic [62:0]        kp_r;
  logic [48:0]        corr_r;

  logic               out_free;
  logic signed [43:0] z_full;
  logic [32:0]        psum;
  logic signed [49:0] innov;
  logic [49:0]        innov_mag;
  logic [33:0]        rem_sh;
  logic               rem_ge;
  logic [50:0]        low_sum;
  logic signed [49:0] nx;
  logic [47:0]        nx_sat;

  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;
  assign out_status     = out_status_r;
  assign out_free       = !out_valid_r || !out_stall;
  assign pop            = (state_r == S_IDLE) && !q_stat.empty && out_free;

  always_comb begin
    z_full    = $signed(diff_r) * $signed({1'b0, cfg.gain});
    psum      = {1'b0, cov_r} + {2'b00, cfg.proc_noise};
    innov     = $signed({{7{z_r[42]}}, z_r}) - $signed({{2{est_r[47]}}, est_r});
    innov_mag = innov[49] ? (50'd0 - innov) : innov;
    rem_sh    = {rem_r, dbit_r};
    rem_ge    = rem_sh >= {1'b0, den_r};
    low_sum   = {21'd0, a_r[9:0], 20'd0} + b_r;
    nx        = $signed({{2{est_r[47]}}, est_r}) +
                (neg_r ? -$signed({1'b0, corr_r}) : $signed({1'b0, corr_r}));
    if (nx[49:47] == 3'b000 || nx[49:47] == 3'b111) begin
      nx_sat = nx[47:0];
    end else if (nx[49]) begin
      nx_sat = {1'b1, 47'd0};
    end else begin
      nx_sat = {1'b0, {47{1'b1}}};
    end

    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (pop && head.status == ggrk_pkg::ST_VALID) state_nxt = S_PRE;
      S_PRE:   state_nxt = S_INNOV;
      S_INNOV: state_nxt = S_DIV;
      S_DIV:   if (cnt_r == 5'(ggrk_pkg::QUO_BITS - 1)) state_nxt = S_MULA;
      S_MULA:  state_nxt = S_MULB;
      S_MULB:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      est_r       <= '0;
      cov_r       <= ggrk_pkg::COV_RST;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (est_load) begin
        est_r <= est_load_val;
      end else if (state_r == S_FIN) begin
        est_r <= nx_sat;
        // The gain never exceeds one, so the product stays below 2^62.
        cov_r <= ppre_r - kp_r[61:30];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_status_r <= head.status;
      out_pred_r   <= (head.status == ggrk_pkg::ST_VALID) ? est_r : 48'd0;
      diff_r       <= head.diff;
    end
    case (state_r)
      S_PRE: begin
        z_r    <= z_full[42:0];
        ppre_r <= psum[32] ? 32'hFFFF_FFFF : psum[31:0];
      end
      S_INNOV: begin
        den_r  <= {1'b0, ppre_r} + {2'b00, cfg.meas_noise};
        neg_r  <= innov[49];
        mag_r  <= innov_mag[48:0];
        rem_r  <= {2'b00, ppre_r[31:1]};
        dbit_r <= ppre_r[0];
        cnt_r  <= '0;
        quo_r  <= '0;
      end
      S_DIV: begin
        rem_r  <= rem_ge ? 33'(rem_sh - {1'b0, den_r}) : rem_sh[32:0];
        dbit_r <= 1'b0;
        quo_r  <= {quo_r[29:0], rem_ge};
        cnt_r  <= cnt_r + 5'd1;
      end
      S_MULA: begin
        // An empty denominator means no gain at all.
        if (den_r == 33'd0) begin
          k_r <= '0;
        end else if (quo_r > ggrk_pkg::ONE_Q30) begin
          k_r <= ggrk_pkg::ONE_Q30;
        end else begin
          k_r <= quo_r;
        end
      end
      S_MULB: begin
        a_r  <= k_r * mag_r[48:20];
        b_r  <= k_r * mag_r[19:0];
        kp_r <= k_r * ppre_r;
      end
      S_SUM: begin
        // The upper partial product is below 2^59, so its top bit is always clear.
        corr_r <= a_r[58:10] + {28'd0, low_sum[50:30]};
      end
      default: ;
    endcase
  end

endmodule

// ===== src/gated_gyro_rate_kalman.sv =====
// Gated gyro-rate Kalman filter. Each input word carries a gyro angle (signed
// Q16.16 degrees) and a target pixel position; each produces exactly one
// output word, in order. A position of (0,0) yields status absent, a target
// that moved farther than jump_threshold pixels yields status jumped, both
// with a zero prediction. Otherwise the angle step, scaled by gain, is fed as
// the measurement of a scalar Kalman filter and the output is the estimate
// held before that update (status valid). A front end classifies words
// combinationally and hands them through a two-word queue to the filter back
// end. Absent and jumped words pass from the queue head straight to the
// output register; a tracked word keeps the back end busy until its update
// is done, with the radix-2 gain divider resolving one quotient bit per cycle
// over 31 bits. Configuration writes are always accepted; writing the initial
// estimate register also loads the filter estimate directly.
`include "gated_gyro_rate_kalman_macros.svh"

module gated_gyro_rate_kalman (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_gyro_angle,
  input  logic [11:0] in_target_x,
  input  logic [11:0] in_target_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_prediction,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  // Configuration registers. The initial estimate has no home of its own:
  // a write goes straight into the filter state.
  logic [9:0]  gain_r;
  logic [6:0]  jump_thr_r;
  logic [30:0] proc_noise_r;
  logic [30:0] meas_noise_r;
  logic        cfg_we;
  logic        est_load;

  ggrk_pkg::kf_cfg_t kf_cfg;
  ggrk_pkg::q_stat_t q_stat;
  ggrk_pkg::item_t   push_item;
  ggrk_pkg::item_t   head;
  logic              push;
  logic              pop;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign est_load  = cfg_we && (cfg_index == ggrk_pkg::REG_INIT_EST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r       <= '0;
      jump_thr_r   <= '0;
      proc_noise_r <= ggrk_pkg::PROC_NOISE_RST;
      meas_noise_r <= ggrk_pkg::MEAS_NOISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ggrk_pkg::REG_GAIN:       gain_r       <= cfg_data[9:0];
        ggrk_pkg::REG_JUMP_THR:   jump_thr_r   <= cfg_data[6:0];
        ggrk_pkg::REG_PROC_NOISE: proc_noise_r <= cfg_data[30:0];
        ggrk_pkg::REG_MEAS_NOISE: meas_noise_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign kf_cfg.gain       = gain_r;
  assign kf_cfg.proc_noise = proc_noise_r;
  assign kf_cfg.meas_noise = meas_noise_r;

  // The front end updates target and angle history as words arrive.
  ggrk_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_gyro_angle (in_gyro_angle),
    .in_target_x   (in_target_x),
    .in_target_y   (in_target_y),
    .jump_thr      (jump_thr_r),
    .q_stat        (q_stat),
    .push          (push),
    .item          (push_item)
  );

  ggrk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // The back end owns the estimate and covariance and the output register.
  ggrk_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (kf_cfg),
    .est_load       (est_load),
    .est_load_val   (cfg_data),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prediction (out_prediction),
    .out_status     (out_status)
  );

  // Untracked words must never carry a prediction.
  `GGRK_ASSERT_NOW(a_untracked_zero, out_valid && out_status != ggrk_pkg::ST_VALID, out_prediction == 48'd0, "untracked word has nonzero prediction")
  // The queue can never be both full and empty.
  `GGRK_ASSERT_NOW(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty), "queue status inconsistent")
  // A word is only taken from the queue when one is there.
  `GGRK_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
  // A pop always presents a word on the output in the next cycle.
  `GGRK_ASSERT_NEXT(a_pop_shows, pop, out_valid, "popped word not presented")

endmodule

// ===== tb/gated_gyro_rate_kalman_tb.sv =====
`timescale 1ns / 100ps

// Keeps a bit-true copy of the filter state and the queue of words the block
// still owes us.
class kalman_scoreboard;
  logic [9:0]         gain_r;
  logic [6:0]         thr_r;
  logic [30:0]        q_noise;
  logic [30:0]        r_noise;
  logic signed [47:0] est;
  logic [31:0]        cov;
  logic [11:0]        last_x, last_y;
  bit                 have_prev;
  logic signed [31:0] prev_angle;
  logic signed [32:0] last_diff;

  logic [47:0]       pred_q[$];
  ggrk_pkg::status_t stat_q[$];
  int                mismatches;
  int                checked;
  int                n_valid, n_absent, n_jumped;

  function void reset_state();
    gain_r = '0;
    thr_r = '0;
    q_noise = ggrk_pkg::PROC_NOISE_RST;
    r_noise = ggrk_pkg::MEAS_NOISE_RST;
    est = '0;
    cov = ggrk_pkg::COV_RST;
    last_x = '0;
    last_y = '0;
    have_prev = 0;
    prev_angle = '0;
    last_diff = '0;
  endfunction

  function void write_reg(ggrk_pkg::reg_idx_t idx, logic [47:0] data);
    case (idx)
      ggrk_pkg::REG_GAIN:       gain_r = data[9:0];
      ggrk_pkg::REG_JUMP_THR:   thr_r = data[6:0];
      ggrk_pkg::REG_PROC_NOISE: q_noise = data[30:0];
      ggrk_pkg::REG_MEAS_NOISE: r_noise = data[30:0];
      ggrk_pkg::REG_INIT_EST:   est = data;
      default: ;
    endcase
  endfunction

  // Works out the output word for one accepted input word.
  function void note_input(logic signed [31:0] angle, logic [11:0] tx, logic [11:0] ty);
    longint dx, dy, dist2, thr2, diff, z, innov, corr, nx;
    longint unsigned p_pre, den, k, mag;
    logic [127:0] prod;
    if (tx == 0 && ty == 0) begin
      have_prev = 0;
      pred_q.push_back('0);
      stat_q.push_back(ggrk_pkg::ST_ABSENT);
      n_absent++;
      return;
    end
    dx = longint'(last_x) - longint'(tx);
    dy = longint'(last_y) - longint'(ty);
    dist2 = dx * dx + dy * dy;
    thr2 = longint'(thr_r) * longint'(thr_r);
    last_x = tx;
    last_y = ty;
    if (dist2 > thr2) begin
      have_prev = 0;
      pred_q.push_back('0);
      stat_q.push_back(ggrk_pkg::ST_JUMPED);
      n_jumped++;
      return;
    end
    diff = have_prev ? longint'(angle) - longint'(prev_angle) : 0;
    // A big upward step after a known rate is treated as a glitch: reuse the last one.
    if (last_diff != 0 && diff > longint'(ggrk_pkg::HALF_DEG)) diff = longint'(last_diff);
    last_diff = diff[32:0];
    prev_angle = angle;
    have_prev = 1;
    z = diff * longint'(gain_r);
    pred_q.push_back(est);
    stat_q.push_back(ggrk_pkg::ST_VALID);
    n_valid++;
    p_pre = longint'(cov) + longint'(q_noise);
    if (p_pre > 64'hFFFF_FFFF) p_pre = 64'hFFFF_FFFF;
    den = p_pre + r_noise;
    k = (den != 0) ? (p_pre << 30) / den : 0;
    if (k > ggrk_pkg::ONE_Q30) k = ggrk_pkg::ONE_Q30;
    innov = z - longint'(est);
    mag = (innov < 0) ? -innov : innov;
    prod = {64'd0, mag} * {64'd0, k};
    corr = prod[93:30];
    if (innov < 0) corr = -corr;
    nx = longint'(est) + corr;
    if (nx > 64'sh7FFF_FFFF_FFFF) nx = 64'sh7FFF_FFFF_FFFF;
    if (nx < -64'sh8000_0000_0000) nx = -64'sh8000_0000_0000;
    est = nx[47:0];
    cov = p_pre - ((k * p_pre) >> 30);
  endfunction

  function void check_result(logic [47:0] pred, logic [1:0] stat);
    logic [47:0]       exp_pred;
    ggrk_pkg::status_t exp_stat;
    checked++;
    if (pred_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected word pred=%h status=%0d", pred, stat);
      return;
    end
    exp_pred = pred_q.pop_front();
    exp_stat = stat_q.pop_front();
    if (pred !== exp_pred || stat !== exp_stat) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: word %0d expected pred=%h status=%0d, got pred=%h status=%0d",
                 checked, exp_pred, exp_stat, pred, stat);
    end
  endfunction

  function int pending();
    return pred_q.size();
  endfunction
endclass

module gated_gyro_rate_kalman_tb;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_gyro_angle = '0;
  logic [11:0] in_target_x = '0;
  logic [11:0] in_target_y = '0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [47:0] out_prediction;
  logic [1:0]  out_status;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  kalman_scoreboard sb = new();

  // The sink runs in one of three modes: random stalls, a long hold-off so the
  // two-word queue fills and the block pushes back on its input, or none.
  bit sink_hold = 0;
  bit sink_fast = 0;
  int long_holds = 0;

  gated_gyro_rate_kalman dut (.*);

  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Timeout with %0d words still owed.", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: every accepted word is checked at the edge where it leaves.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_prediction, out_status);
  end

  // Stall generator. A fresh number of stall cycles is drawn for every word.
  initial begin
    int wait_n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        long_holds++;
        sink_hold = 0;
      end
      wait_n = sink_fast ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
      if (wait_n > 0) begin
        out_stall <= 1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  int idle_max = 18;

  // Offers one word and waits for the block to take it.
  task automatic send_word(logic [31:0] angle, logic [11:0] tx, logic [11:0] ty);
    int gap;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_gyro_angle <= angle;
    in_target_x <= tx;
    in_target_y <= ty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(angle, tx, ty);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    // Leave room for the back end to settle before touching registers.
    repeat (50) @(posedge clk);
  endtask

  // Holds the write offered until it is taken; the caller drops valid.
  task automatic write_cfg(ggrk_pkg::reg_idx_t idx, logic [47:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [9:0] g, logic [6:0] t, logic [30:0] q, logic [30:0] r,
                           logic [47:0] x0);
    write_cfg(ggrk_pkg::REG_GAIN, g);
    write_cfg(ggrk_pkg::REG_JUMP_THR, t);
    write_cfg(ggrk_pkg::REG_PROC_NOISE, q);
    write_cfg(ggrk_pkg::REG_MEAS_NOISE, r);
    write_cfg(ggrk_pkg::REG_INIT_EST, x0);
    cfg_valid <= 0;
  endtask

  // A tracked run: small pixel steps and small angle steps, with an occasional
  // big jump in angle to hit the glitch-reuse path.
  task automatic track_burst(int n);
    logic [11:0] x, y;
    logic [31:0] a;
    x = $urandom_range(1, 4095);
    y = $urandom_range(0, 4095);
    a = $urandom();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: a = a + $urandom_range(32769, 2000000);
        1: a = a - $urandom_range(0, 2000000);
        2: a = $urandom();
        default: a = a + $urandom_range(0, 65535) - 32768;
      endcase
      x = x + $urandom_range(0, 8) - 4;
      y = y + $urandom_range(0, 8) - 4;
      if (x == 0 && y == 0) x = 1;
      send_word(a, x, y);
    end
  endtask

  task automatic random_words(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_word($urandom(), 12'd0, 12'd0);
      else if (r < 3) send_word($urandom(), $urandom(), $urandom());
      else track_burst($urandom_range(3, 12));
    end
  endtask

  int sent_mark;

  initial begin
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset settings, absent, first sample, edges of every field.
    send_word(32'h0, 12'd0, 12'd0);
    send_word(32'h7FFF_FFFF, 12'd0, 12'd0);
    send_word(32'h0001_0000, 12'd10, 12'd10);
    send_word(32'h0001_0000, 12'd10, 12'd10);
    drain();
    configure(10'd1000, 7'd100, 31'h7FFF_FFFF, 31'd0, 48'h7FFF_FFFF_FFFF);
    send_word(32'h8000_0000, 12'd4095, 12'd4095);
    send_word(32'h7FFF_FFFF, 12'd4095, 12'd4095);
    send_word(32'h8000_0000, 12'd4095, 12'd4030);
    send_word(32'h8000_0000, 12'd4095, 12'd4030);
    send_word(32'h8000_4000, 12'd4000, 12'd4030);
    send_word(32'h8000_C000, 12'd0, 12'd1);
    send_word(32'h8000_C000, 12'd1, 12'd0);
    send_word(32'h8001_C000, 12'd2, 12'd1);
    send_word(32'h8000_0000, 12'd2, 12'd1);
    send_word(32'hFFFF_FFFF, 12'd0, 12'd0);
    drain();
    configure(10'd0, 7'd0, 31'd0, 31'd0, 48'h8000_0000_0000);
    send_word(32'h5555_5555, 12'hAAA, 12'h555);
    send_word(32'hAAAA_AAAA, 12'hAAA, 12'h555);
    send_word(32'h1234_5678, 12'hAAB, 12'h555);
    drain();
    configure(10'h3FF, 7'h7F, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 48'h8000_0000_0000);
    send_word(32'h0, 12'h555, 12'hAAA);
    send_word(32'h7FFF_0000, 12'h555, 12'hAAA);
    send_word(32'h0, 12'h555, 12'hAAA);
    drain();

    // Random phases, each under a new register setting.
    for (int ph = 0; ph < 6; ph++) begin
      configure($urandom_range(0, 1000), $urandom_range(0, 100), $urandom(), $urandom(),
                {$urandom(), $urandom()});
      idle_max = (ph == 2) ? 0 : 18;
      sink_fast = (ph == 3);
      if (ph == 1) sink_hold = 1;
      random_words(20);
      if (ph == 4) begin
        // Pause until everything has come back, then carry on.
        in_valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        random_words(10);
      end
      drain();
    end

    $display("Checked %0d words: %0d tracked, %0d absent, %0d jumped; %0d long hold-offs.",
             sb.checked, sb.n_valid, sb.n_absent, sb.n_jumped, long_holds);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words owed.", sb.mismatches, sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ggrk_pkg.sv
src/ggrk_front.sv
src/ggrk_queue.sv
src/ggrk_back.sv
src/gated_gyro_rate_kalman.sv
tb/gated_gyro_rate_kalman_tb.sv
